// File: design/kvc_pkg.sv
`timescale 1ns / 1ps

package kvc_pkg;

    localparam int MAX_VELOCITY  = 127;
    localparam int FRACTION_BITS = 8;

    localparam int TICK_W   = 16;
    localparam int GAIN_W   = 32;
    localparam int OFFSET_W = 24;
    localparam int BASE_W   = 16;
    localparam int VEL_W    = 7;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 3;

    // positive press denominator: t * 2^F plus an offset below 2^(OFFSET_W-1)
    localparam int DEN_W = ((TICK_W + FRACTION_BITS) > (OFFSET_W - 1)
                           ? (TICK_W + FRACTION_BITS) : (OFFSET_W - 1)) + 1;
    localparam int SUM_W = DEN_W + 1;
    // magnitude of A shifted by F (press) or by one (release)
    localparam int NUM_W = GAIN_W + ((FRACTION_BITS > 1) ? FRACTION_BITS : 1);
    localparam int S_W   = NUM_W + 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WHITE_GAIN   = 3'd0,
        REG_WHITE_OFFSET = 3'd1,
        REG_WHITE_BASE   = 3'd2,
        REG_BLACK_GAIN   = 3'd3,
        REG_BLACK_OFFSET = 3'd4,
        REG_BLACK_BASE   = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic signed [GAIN_W-1:0]   gain;
        logic signed [OFFSET_W-1:0] offset;
        logic signed [BASE_W-1:0]   base;
    } coef_t;

    typedef struct packed {
        logic                     special;
        logic                     special_max;
        logic                     release_op;
        logic                     neg;
        logic [NUM_W-1:0]         num;
        logic [DEN_W-1:0]         den;
        logic signed [BASE_W-1:0] base;
    } kvc_item_t;

endpackage

// File: design/kvc_front.sv
`timescale 1ns / 1ps

module kvc_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic              req_type,
    input  logic              is_black,
    input  logic [15:0]       tick_count,
    input  kvc_pkg::coef_t    coef_white,
    input  kvc_pkg::coef_t    coef_black,
    output logic              item_valid,
    output kvc_pkg::kvc_item_t item
);
    import kvc_pkg::*;

    coef_t                   coef;
    logic signed [SUM_W-1:0] t_fx;
    logic signed [SUM_W-1:0] den_sum;
    logic [GAIN_W-1:0]       a_mag;
    kvc_item_t               item_next;
    logic                    item_valid_reg;
    kvc_item_t               item_reg;

    always_comb
    begin
        coef    = is_black ? coef_black : coef_white;
        t_fx    = $signed(SUM_W'(tick_count) << FRACTION_BITS);
        den_sum = req_type ? t_fx : t_fx + SUM_W'(coef.offset);
        a_mag   = coef.gain[GAIN_W-1] ? GAIN_W'(-coef.gain) : GAIN_W'(coef.gain);

        item_next.special     = den_sum[SUM_W-1] || (den_sum == '0);
        item_next.special_max = !coef.gain[GAIN_W-1] && (coef.gain != '0);
        item_next.release_op  = req_type;
        item_next.neg         = coef.gain[GAIN_W-1];
        item_next.num         = req_type ? (NUM_W'(a_mag) << 1)
                                         : (NUM_W'(a_mag) << FRACTION_BITS);
        item_next.den         = den_sum[DEN_W-1:0];
        item_next.base        = coef.base;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_next;
        end
    end

    assign item_valid = item_valid_reg;
    assign item       = item_reg;

endmodule

// File: design/kvc_queue.sv
`timescale 1ns / 1ps

module kvc_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr,
    input  kvc_pkg::kvc_item_t wr_data,
    input  logic               rd,
    output logic               not_empty,
    output logic               full,
    output kvc_pkg::kvc_item_t rd_data
);
    import kvc_pkg::*;

    kvc_item_t  mem_reg [0:1];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_rd;

    assign do_rd     = rd && (count_reg != 2'd0);
    assign not_empty = (count_reg != 2'd0);
    assign full      = (count_reg == 2'd2);
    assign rd_data   = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (wr)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (wr && !do_rd)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (!wr && do_rd)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        wr && full |-> do_rd)
        else $error("queue overflow");
`endif

endmodule

// File: design/kvc_back.sv
`timescale 1ns / 1ps

module kvc_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  kvc_pkg::kvc_item_t   in_item,
    output logic                 done,
    output logic [6:0]           velocity,
    output logic                 was_clamped
);
    import kvc_pkg::*;

    localparam logic [S_W-1:0] ROUND_ADD = S_W'((1 << FRACTION_BITS) - 1);

    // one quotient bit per stage, restoring division on magnitudes
    logic             stg_valid_reg [0:NUM_W];
    kvc_item_t        stg_item_reg  [0:NUM_W];
    logic [DEN_W-1:0] stg_rem_reg   [0:NUM_W];
    logic [DEN_W-1:0] rem_next      [0:NUM_W-1];
    kvc_item_t        stg_item_next [0:NUM_W-1];

    logic                  f1_valid_reg;
    logic                  f1_special_reg;
    logic                  f1_special_max_reg;
    logic                  f1_release_reg;
    logic signed [S_W-1:0] f1_s_reg;
    logic signed [NUM_W:0] q_signed;
    logic signed [S_W-1:0] s_next;

    logic signed [S_W-1:0] v;
    logic [VEL_W-1:0]      velocity_next;
    logic                  clamped_next;
    logic                  done_reg;
    logic [VEL_W-1:0]      velocity_reg;
    logic                  was_clamped_reg;

    always_comb
    begin
        logic [DEN_W:0] trial;
        for (int k = 0; k < NUM_W; k++)
        begin
            stg_item_next[k] = stg_item_reg[k];
            trial = {stg_rem_reg[k], stg_item_reg[k].num[NUM_W-1]};
            if (trial >= {1'b0, stg_item_reg[k].den})
            begin
                rem_next[k] = DEN_W'(trial - {1'b0, stg_item_reg[k].den});
                stg_item_next[k].num = {stg_item_reg[k].num[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[k] = trial[DEN_W-1:0];
                stg_item_next[k].num = {stg_item_reg[k].num[NUM_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= NUM_W; k++)
            begin
                stg_valid_reg[k] <= 1'b0;
            end
        end
        else
        begin
            stg_valid_reg[0] <= in_valid;
            for (int k = 0; k < NUM_W; k++)
            begin
                stg_valid_reg[k+1] <= stg_valid_reg[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        stg_item_reg[0] <= in_item;
        stg_rem_reg[0]  <= '0;
        for (int k = 0; k < NUM_W; k++)
        begin
            stg_item_reg[k+1] <= stg_item_next[k];
            stg_rem_reg[k+1]  <= rem_next[k];
        end
    end

    // apply sign of A, then add C on a press
    always_comb
    begin
        q_signed = stg_item_reg[NUM_W].neg ? -$signed({1'b0, stg_item_reg[NUM_W].num})
                                           : $signed({1'b0, stg_item_reg[NUM_W].num});
        s_next   = stg_item_reg[NUM_W].release_op ? S_W'(q_signed)
                 : S_W'(q_signed) + S_W'(stg_item_reg[NUM_W].base);
    end

    // truncate toward zero, then saturate
    always_comb
    begin
        if (f1_release_reg)
        begin
            v = f1_s_reg;
        end
        else if (f1_s_reg[S_W-1])
        begin
            v = (f1_s_reg + $signed(ROUND_ADD)) >>> FRACTION_BITS;
        end
        else
        begin
            v = f1_s_reg >>> FRACTION_BITS;
        end

        if (f1_special_reg)
        begin
            velocity_next = f1_special_max_reg ? VEL_W'(MAX_VELOCITY) : '0;
            clamped_next  = 1'b1;
        end
        else if (v > $signed(S_W'(MAX_VELOCITY)))
        begin
            velocity_next = VEL_W'(MAX_VELOCITY);
            clamped_next  = 1'b1;
        end
        else if (v[S_W-1])
        begin
            velocity_next = '0;
            clamped_next  = 1'b1;
        end
        else
        begin
            velocity_next = v[VEL_W-1:0];
            clamped_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            f1_valid_reg <= stg_valid_reg[NUM_W];
            done_reg     <= f1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        f1_special_reg     <= stg_item_reg[NUM_W].special;
        f1_special_max_reg <= stg_item_reg[NUM_W].special_max;
        f1_release_reg     <= stg_item_reg[NUM_W].release_op;
        f1_s_reg           <= s_next;
        velocity_reg       <= velocity_next;
        was_clamped_reg    <= clamped_next;
    end

    assign done        = done_reg;
    assign velocity    = velocity_reg;
    assign was_clamped = was_clamped_reg;

`ifndef SYNTHESIS
    a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
        stg_valid_reg[NUM_W] && !stg_item_reg[NUM_W].special
        |-> stg_rem_reg[NUM_W] < stg_item_reg[NUM_W].den)
        else $error("divider remainder not below divisor");
    a_special_clamps: assert property (@(posedge clk) disable iff (!rst_n)
        f1_valid_reg && f1_special_reg |=> done_reg && was_clamped_reg)
        else $error("nonpositive denominator not flagged as clamped");
`endif

endmodule

// File: design/key_velocity_curve_core.sv
// A start transfer passes the front register, the queue, the divider stages and f1 before done strobes.
// Throughput: one event per cycle; the 40-stage divider pipeline sets the latency.
// busy stays low in use since the back end drains every cycle.
// Reset (rst_n, async, active low) clears the valid flags, queue pointers and all coefficients to zero.
`timescale 1ns / 1ps

module key_velocity_curve_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           req_type,
    input  logic                           is_black,
    input  logic [15:0]                    tick_count,
    output logic                           done,
    output logic [6:0]                     velocity,
    output logic                           was_clamped,
    input  logic                           cfg_wr,
    input  logic [kvc_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [kvc_pkg::CFG_W-1:0]      cfg_data
);
    import kvc_pkg::*;

    coef_t     white_reg;
    coef_t     black_reg;
    logic      accept;
    logic      front_valid;
    kvc_item_t front_item;
    logic      q_not_empty;
    logic      q_full;
    kvc_item_t q_item;

    assign busy   = q_full;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            white_reg <= '0;
            black_reg <= '0;
        end
        else if (cfg_wr)
        begin
            case (cfg_addr)
                REG_WHITE_GAIN:   white_reg.gain   <= cfg_data[GAIN_W-1:0];
                REG_WHITE_OFFSET: white_reg.offset <= cfg_data[OFFSET_W-1:0];
                REG_WHITE_BASE:   white_reg.base   <= cfg_data[BASE_W-1:0];
                REG_BLACK_GAIN:   black_reg.gain   <= cfg_data[GAIN_W-1:0];
                REG_BLACK_OFFSET: black_reg.offset <= cfg_data[OFFSET_W-1:0];
                REG_BLACK_BASE:   black_reg.base   <= cfg_data[BASE_W-1:0];
                default: ;
            endcase
        end
    end

    kvc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .req_type   (req_type),
        .is_black   (is_black),
        .tick_count (tick_count),
        .coef_white (white_reg),
        .coef_black (black_reg),
        .item_valid (front_valid),
        .item       (front_item)
    );

    kvc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (front_valid),
        .wr_data   (front_item),
        .rd        (1'b1),
        .not_empty (q_not_empty),
        .full      (q_full),
        .rd_data   (q_item)
    );

    kvc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (q_not_empty),
        .in_item     (q_item),
        .done        (done),
        .velocity    (velocity),
        .was_clamped (was_clamped)
    );

`ifndef SYNTHESIS
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##45 done)
        else $error("result did not appear at fixed latency");
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("queue filled although the back end drains every cycle");
`endif

endmodule

// File: test/kvc_checker.sv
`timescale 1ns / 1ps

module kvc_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic        req_type,
    input  logic        is_black,
    input  logic [15:0] tick_count,
    input  logic        done,
    input  logic [6:0]  velocity,
    input  logic        was_clamped,
    input  logic        cfg_wr,
    input  logic [kvc_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [kvc_pkg::CFG_W-1:0]     cfg_data,
    output int          errors,
    output int          pending
);
    import kvc_pkg::*;

    typedef struct packed {
        logic [6:0] vel;
        logic       clamped;
    } vel_result_t;

    logic signed [GAIN_W-1:0]   gain_r [2];
    logic signed [OFFSET_W-1:0] offset_r [2];
    logic signed [BASE_W-1:0]   base_r [2];
    vel_result_t expected_vel [$];

    function automatic vel_result_t curve_velocity(logic rel, logic blk, logic [15:0] t);
        longint a, b, c, den, q, v;
        vel_result_t r;
        a = longint'(gain_r[blk]);
        b = longint'(offset_r[blk]);
        c = longint'(base_r[blk]);
        den = longint'(t) <<< FRACTION_BITS;
        if (!rel)
            den = den + b;
        if (den <= 0)
        begin
            r.vel = (a > 0) ? 7'(MAX_VELOCITY) : 7'd0;
            r.clamped = 1'b1;
            return r;
        end
        if (rel)
            v = (a * 2) / den;
        else
        begin
            q = (a * (64'sd1 <<< FRACTION_BITS)) / den;
            v = (q + c) / (64'sd1 <<< FRACTION_BITS);
        end
        if (v > MAX_VELOCITY)
        begin
            r.vel = 7'(MAX_VELOCITY);
            r.clamped = 1'b1;
        end
        else if (v < 0)
        begin
            r.vel = 7'd0;
            r.clamped = 1'b1;
        end
        else
        begin
            r.vel = 7'(v);
            r.clamped = 1'b0;
        end
        return r;
    endfunction

    assign pending = expected_vel.size();

    always @(posedge clk or negedge rst_n)
    begin
        vel_result_t got;
        vel_result_t exp_r;
        if (!rst_n)
        begin
            errors = 0;
            expected_vel.delete();
            for (int i = 0; i < 2; i++)
            begin
                gain_r[i] = '0;
                offset_r[i] = '0;
                base_r[i] = '0;
            end
        end
        else
        begin
            if (done)
            begin
                got.vel = velocity;
                got.clamped = was_clamped;
                if (expected_vel.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result vel=%0d clamp=%0b", velocity, was_clamped);
                end
                else
                begin
                    exp_r = expected_vel.pop_front();
                    if (got !== exp_r)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("velocity exp %0d/%0b got %0d/%0b",
                                     exp_r.vel, exp_r.clamped, got.vel, got.clamped);
                    end
                end
            end
            if (start && !busy)
                expected_vel.push_back(curve_velocity(req_type, is_black, tick_count));
            if (cfg_wr)
            begin
                case (cfg_idx_t'(cfg_addr))
                    REG_WHITE_GAIN:   gain_r[0] = cfg_data[GAIN_W-1:0];
                    REG_WHITE_OFFSET: offset_r[0] = cfg_data[OFFSET_W-1:0];
                    REG_WHITE_BASE:   base_r[0] = cfg_data[BASE_W-1:0];
                    REG_BLACK_GAIN:   gain_r[1] = cfg_data[GAIN_W-1:0];
                    REG_BLACK_OFFSET: offset_r[1] = cfg_data[OFFSET_W-1:0];
                    REG_BLACK_BASE:   base_r[1] = cfg_data[BASE_W-1:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

// File: test/tb_key_velocity_curve_core.sv
`timescale 1ns / 1ps

module tb_key_velocity_curve_core;
    import kvc_pkg::*;

    localparam int LATENCY = 44;
    localparam int WATCHDOG = 2000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic req_type = 1'b0;
    logic is_black = 1'b0;
    logic [15:0] tick_count = '0;
    logic done;
    logic [6:0] velocity;
    logic was_clamped;
    logic cfg_wr = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr = '0;
    logic [CFG_W-1:0] cfg_data = '0;
    int errors;
    int pending;
    int quiet_cycles = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    key_velocity_curve_core uut (.*);

    kvc_checker checker_i (.*);

    // watchdog: cycles with no transfer on either side
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG)
        begin
            $display("key_velocity_curve_core: mismatch");
            $finish;
        end
    end

    task automatic write_coef(cfg_idx_t idx, logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_wr <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_wr <= 1'b0;
    endtask

    task automatic load_curve(logic [31:0] wa, logic [23:0] wb, logic [15:0] wc,
                              logic [31:0] ba, logic [23:0] bb, logic [15:0] bc);
        write_coef(REG_WHITE_GAIN, wa);
        write_coef(REG_WHITE_OFFSET, {{8{wb[23]}}, wb});
        write_coef(REG_WHITE_BASE, {{16{wc[15]}}, wc});
        write_coef(REG_BLACK_GAIN, ba);
        write_coef(REG_BLACK_OFFSET, {{8{bb[23]}}, bb});
        write_coef(REG_BLACK_BASE, {{16{bc[15]}}, bc});
    endtask

    // start stays high across back-to-back transfers; lowered only for a gap or by drain
    task automatic send_event(logic rel, logic blk, logic [15:0] t, bit may_gap);
        if (may_gap && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        start <= 1'b1;
        req_type <= rel;
        is_black <= blk;
        tick_count <= t;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);
    endtask

    function automatic logic [15:0] rand_ticks();
        case ($urandom_range(0, 3))
            0: return 16'($urandom_range(0, 20));
            1: return 16'($urandom_range(0, 600));
            2: return 16'($urandom_range(65500, 65535));
            default: return 16'($urandom);
        endcase
    endfunction

    initial
    begin
        logic [15:0] dir_ticks [8] = '{16'd0, 16'd1, 16'd2, 16'd100, 16'h7FFF,
                                       16'h8000, 16'hFFFE, 16'hFFFF};
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        // reset coefficients: everything should land on zero, clamped or not
        for (int i = 0; i < 4; i++)
            send_event(i[0], i[1], dir_ticks[i * 2 + 1], 1'b0);
        drain();

        load_curve(32'd500000, 24'd256, 16'd2560, 32'hFFFF0000, -24'sd1000, 16'h8000);
        foreach (dir_ticks[i])
            send_event(1'(i % 2), 1'((i / 2) % 2), dir_ticks[i], 1'b0);
        drain();

        // extremes: max gain, most negative offset/base; min gain, max offset/base
        load_curve(32'h7FFFFFFF, 24'h800000, 16'h8000,
                   32'h80000000, 24'h7FFFFF, 16'h7FFF);
        foreach (dir_ticks[i])
            send_event(1'(i % 2), 1'((i / 2) % 2), dir_ticks[i], 1'b0);
        drain();

        for (int phase = 0; phase < 7; phase++)
        begin
            int n_items;
            n_items = 100;
            if (phase == 6)
                load_curve($urandom, 24'($urandom), 16'($urandom),
                           $urandom, 24'($urandom), 16'($urandom));
            else
                load_curve($urandom_range(1000, 2000000), 24'($urandom_range(0, 20000)) -
                           24'd2000, 16'($urandom_range(0, 40000)) - 16'd8000,
                           $urandom_range(1000, 4000000), 24'($urandom_range(0, 20000)) -
                           24'd2000, 16'($urandom));
            if (phase == 3)
                write_coef(cfg_idx_t'(3'd6), $urandom);
            for (int k = 0; k < n_items; k++)
                send_event(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                           rand_ticks(), phase < 6);
            drain();
        end

        if (errors == 0)
            $display("key_velocity_curve_core: match");
        else
            $display("key_velocity_curve_core: mismatch");
        $finish;
    end

endmodule

// File: filelist.f
design/kvc_pkg.sv
design/kvc_front.sv
design/kvc_queue.sv
design/kvc_back.sv
design/key_velocity_curve_core.sv
test/kvc_checker.sv
test/tb_key_velocity_curve_core.sv
